/* rtl/lagged_fibonacci_random_mod_assert.svh */
`ifndef LAGGED_FIBONACCI_RANDOM_MOD_ASSERT_SVH
`define LAGGED_FIBONACCI_RANDOM_MOD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFRM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lagged fibonacci generator check failed");

// Plain invariant, disabled while reset is asserted.
`define LFRM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("lagged fibonacci generator invariant failed");

`endif

/* rtl/lfrm_pkg.sv */
`timescale 1ns / 1ps

package lfrm_pkg;

    localparam int LFRM_WORD_WIDTH = 32;
    localparam int LFRM_MOD_WIDTH  = 32;
    localparam int LFRM_LONG_LAG   = 17;
    localparam int LFRM_SHORT_LAG  = 5;
    localparam int LFRM_SEED_TOP   = 1;
    localparam int LFRM_SEED_NEXT  = 2;

    // Reset word of table entry idx (0 is the lowest entry), wrapped to width bits.
    function automatic logic [63:0] lfrm_seed(input int idx, input int width);
        logic [63:0] mask;
        logic [63:0] words [LFRM_LONG_LAG];
        mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
        words[LFRM_LONG_LAG-1] = 64'(LFRM_SEED_TOP) & mask;
        words[LFRM_LONG_LAG-2] = 64'(LFRM_SEED_NEXT) & mask;
        for (int n = LFRM_LONG_LAG - 3; n >= 0; n--) begin
            words[n] = (words[n+1] + words[n+2]) & mask;
        end
        return words[idx];
    endfunction

endpackage

/* rtl/lfrm_divider.sv */
`timescale 1ns / 1ps

module lfrm_divider import lfrm_pkg::*; #(
    parameter int WORD_WIDTH = LFRM_WORD_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [WORD_WIDTH-1:0]     dividend,
    input  logic [LFRM_MOD_WIDTH-1:0] divisor,
    output logic                      done,
    output logic [LFRM_MOD_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_WIDTH - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [WORD_WIDTH-1:0]     dvd_reg;
    logic [LFRM_MOD_WIDTH-1:0] dvs_reg;
    logic [LFRM_MOD_WIDTH-1:0] rem_reg;

    logic [LFRM_MOD_WIDTH:0]   trial;
    logic [LFRM_MOD_WIDTH:0]   diff;
    logic [LFRM_MOD_WIDTH-1:0] rem_next;

    assign trial    = {rem_reg, dvd_reg[WORD_WIDTH-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = diff[LFRM_MOD_WIDTH] ? trial[LFRM_MOD_WIDTH-1:0]
                                           : diff[LFRM_MOD_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[WORD_WIDTH-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lagged_fibonacci_random_mod.sv */
`timescale 1ns / 1ps
// Additive lagged Fibonacci generator with lags 17 and 5.
// Input channel s_: each item carries a modulus and requests one random draw.
// Result channel m_: one item per request, value = new lagged sum mod modulus.
// A request adds two table words, writes the sum back and reduces it with a
// restoring divider that retires one quotient bit per cycle.
// From acceptance a request passes through ST_ADD, ST_DIVIDE and ST_FINISH,
// and ST_DIVIDE lasts until the bit-serial divider is done; one request is in
// flight at a time, so the next item is taken only after the last has left ST_FINISH.
// A zero modulus leaves the table untouched, skips the divider and returns 0
// from ST_FINISH, and the next item can be taken once that result is handed over.
// s_ready is high whenever the sequencer is idle, even while a finished item
// still waits in the output register; a stalled receiver holds m_valid and
// m_value and only blocks the next item from leaving ST_FINISH.
// Synchronous reset (aresetn low) returns the table to its seed through
// per-entry valid bits, sets the pointers to their start positions and drops
// any pending item.

module lagged_fibonacci_random_mod import lfrm_pkg::*; #(
    parameter int WORD_WIDTH = LFRM_WORD_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [LFRM_MOD_WIDTH-1:0] s_modulus,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [LFRM_MOD_WIDTH-1:0] m_value
);

    `include "lagged_fibonacci_random_mod_assert.svh"

    localparam int DEPTH = LFRM_LONG_LAG;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] LONG_START  = IDX_W'(LFRM_LONG_LAG - 1);
    localparam logic [IDX_W-1:0] SHORT_START = IDX_W'(LFRM_SHORT_LAG - 1);
    localparam logic [IDX_W:0]   LAG_GAP     = (IDX_W+1)'(LFRM_LONG_LAG - LFRM_SHORT_LAG);
    localparam logic [IDX_W:0]   SHORT_LAG_W = (IDX_W+1)'(LFRM_SHORT_LAG);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          long_idx_reg;
    logic [IDX_W-1:0]          short_idx_reg;
    logic [DEPTH-1:0]          valid_reg;
    logic [LFRM_MOD_WIDTH-1:0] modulus_reg;
    logic                      zero_reg;
    logic                      m_valid_reg;
    logic [LFRM_MOD_WIDTH-1:0] m_value_reg;

    logic [WORD_WIDTH-1:0]     mem [DEPTH];
    logic [WORD_WIDTH-1:0]     rd_a_reg;
    logic [WORD_WIDTH-1:0]     rd_b_reg;
    logic [WORD_WIDTH-1:0]     seed_word [DEPTH];

    logic                      accept;
    logic [WORD_WIDTH-1:0]     sum_next;
    logic [IDX_W-1:0]          long_idx_next;
    logic [IDX_W-1:0]          short_idx_next;
    logic                      div_start;
    logic                      div_done;
    logic [LFRM_MOD_WIDTH-1:0] div_rem;

    for (genvar i = 0; i < DEPTH; i++) begin : g_seed
        localparam logic [63:0] SEED_FULL = lfrm_seed(i, WORD_WIDTH);
        assign seed_word[i] = SEED_FULL[WORD_WIDTH-1:0];
    end

    assign accept         = s_valid && s_ready;
    assign s_ready        = (state_reg == ST_IDLE);
    assign sum_next       = rd_a_reg + rd_b_reg;
    assign long_idx_next  = (long_idx_reg == '0) ? LAST_IDX : long_idx_reg - 1'b1;
    assign short_idx_next = (short_idx_reg == '0) ? LAST_IDX : short_idx_reg - 1'b1;
    assign div_start      = (state_reg == ST_ADD);

    lfrm_divider #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum_next),
        .divisor   (modulus_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADD) begin
            mem[long_idx_reg] <= sum_next;
        end
        if (accept) begin
            rd_a_reg <= valid_reg[long_idx_reg] ? mem[long_idx_reg]
                                                : seed_word[long_idx_reg];
            rd_b_reg <= valid_reg[short_idx_reg] ? mem[short_idx_reg]
                                                 : seed_word[short_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            long_idx_reg  <= LONG_START;
            short_idx_reg <= SHORT_START;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        modulus_reg <= s_modulus;
                        zero_reg    <= (s_modulus == '0);
                        state_reg   <= (s_modulus == '0) ? ST_FINISH : ST_ADD;
                    end
                end
                ST_ADD: begin
                    valid_reg[long_idx_reg] <= 1'b1;
                    long_idx_reg  <= long_idx_next;
                    short_idx_reg <= short_idx_next;
                    state_reg     <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= zero_reg ? '0 : div_rem;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    `LFRM_ASSERT_NOW(a_rem_below_modulus, aclk, aresetn,
        div_done, div_rem < modulus_reg)
    `LFRM_ASSERT_NOW(a_done_only_dividing, aclk, aresetn,
        div_done, state_reg == ST_DIVIDE)
    `LFRM_ASSERT_ALWAYS(a_pointer_gap, aclk, aresetn,
        ({1'b0, long_idx_reg} == {1'b0, short_idx_reg} + LAG_GAP) ||
        ({1'b0, long_idx_reg} + SHORT_LAG_W == {1'b0, short_idx_reg}))

endmodule
